// File: rtl/core/tcr_pkg.sv
// shared constants, types and helpers of the textured column renderer
`default_nettype none

package tcr_pkg;

   localparam int SCREEN_HEIGHT      = 512;
   localparam int SCREEN_WIDTH       = 1024;
   localparam int TEXTURE_COUNT      = 4;
   localparam int TEXTURE_MAX_SIDE   = 64;

   localparam int TEX_SIDE_LOG2      = $clog2(TEXTURE_MAX_SIDE);
   localparam int TEXELS_PER_TEXTURE = 4096;
   localparam int TEXEL_ADDR_BITS    = 12;
   localparam int RAM_DEPTH          = TEXTURE_COUNT * TEXELS_PER_TEXTURE;
   localparam int RAM_ADDR_BITS      = $clog2(RAM_DEPTH);
   localparam int COLOR_BITS         = 32;

   localparam int HEIGHT_LOG2_MAX    = 6;
   localparam int FRAC_BITS          = 16;
   localparam int STEP_BITS          = FRAC_BITS + HEIGHT_LOG2_MAX + 1;
   localparam int DIV_CNT_BITS       = $clog2(STEP_BITS);
   localparam int POS_BITS           = 40;
   localparam int START_BITS         = 18;
   localparam int ROW_BITS           = $clog2(SCREEN_HEIGHT + 1);
   localparam int COL_CMP_BITS       = 12;

   localparam int CMD_DEPTH          = 4;
   localparam int CMD_PTR_BITS       = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS       = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH          = 4;
   localparam int OUT_PTR_BITS       = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS       = $clog2(OUT_DEPTH + 1);

   // input opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_EMIT  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_CEILING     = 2'd0;
   localparam logic [1:0] CSR_FLOOR       = 2'd1;
   localparam logic [1:0] CSR_TEX_WIDTH   = 2'd2;
   localparam logic [1:0] CSR_HEIGHT_LOG2 = 2'd3;

   // commands from front to back
   typedef logic [1:0] cmd_kind_type;
   localparam cmd_kind_type CMD_LOAD  = 2'd0;
   localparam cmd_kind_type CMD_START = 2'd1;
   localparam cmd_kind_type CMD_END   = 2'd2;
   localparam cmd_kind_type CMD_EMIT  = 2'd3;

   typedef struct packed {
      logic [COLOR_BITS-1:0] ceiling_color;
      logic [COLOR_BITS-1:0] floor_color;
      logic [6:0]            texture_width;
      logic [2:0]            height_log2;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic [1:0]                  tex;
      logic [TEXEL_ADDR_BITS-1:0]  addr;
      logic [COLOR_BITS-1:0]       value;
      logic [10:0]                 x;
      logic [8:0]                  top;
      logic [8:0]                  bottom;
      logic [TEX_SIDE_LOG2-1:0]    tc;
      logic [STEP_BITS-1:0]        step;
      logic [POS_BITS-1:0]         pos;
   } cmd_type;

   function automatic logic [2:0] clamp_height_log2(input logic [2:0] hl);
      if (hl > 3'(HEIGHT_LOG2_MAX)) begin
         return 3'(HEIGHT_LOG2_MAX);
      end
      return hl;
   endfunction

   function automatic logic [1:0] pick_texture(input logic [1:0] sel);
      if ({1'b0, sel} >= 3'(TEXTURE_COUNT)) begin
         return 2'(TEXTURE_COUNT - 1);
      end
      return sel;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tcr_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module tcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/tcr_front.sv
// front end: accepts words, divides out the column step and multiplies out the start position
`default_nettype none

module tcr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [1:0]       req_op,
   input  wire logic [1:0]       req_texture_select,
   input  wire logic [11:0]      req_texel_address,
   input  wire logic [31:0]      req_texel_value,
   input  wire logic [10:0]      req_column_x,
   input  wire logic [8:0]       req_wall_top,
   input  wire logic [8:0]       req_wall_bottom,
   input  wire logic [15:0]      req_wall_full_height,
   input  wire logic [6:0]       req_texture_column,
   input  wire tcr_pkg::cfg_type cfg,
   input  wire logic             q_full,
   output logic                  q_push,
   output tcr_pkg::cmd_type      q_data
);
   import tcr_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_MUL  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [10:0]               x_ff;
   logic [8:0]                top_ff, bot_ff;
   logic [1:0]                tex_ff;
   logic [TEX_SIDE_LOG2-1:0]  tc_ff;
   logic [15:0]               fh_ff;
   logic [15:0]               rem_ff;
   logic [STEP_BITS-1:0]      quo_ff;
   logic [POS_BITS-1:0]       pos_ff;

   logic                      accept;
   logic                      offscreen;
   logic                      start_col;
   logic [6:0]                tw;
   logic [6:0]                tc_cl;
   logic [15:0]               fh_cl;
   logic [2:0]                hl;
   logic [STEP_BITS-1:0]      dividend;
   logic [16:0]               trial;
   logic                      ge;
   logic signed [START_BITS-1:0]           start_s;
   logic signed [START_BITS+STEP_BITS:0]   prod;

   assign req_full  = (state_ff != F_IDLE) | q_full;
   assign accept    = req_push & ~req_full;
   assign offscreen = COL_CMP_BITS'(req_column_x) >= COL_CMP_BITS'(SCREEN_WIDTH);
   assign start_col = accept & (req_op == OP_START) & ~offscreen;

   always_comb begin
      if (cfg.texture_width == 7'd0) begin
         tw = 7'd1;
      end else if (cfg.texture_width > 7'(TEXTURE_MAX_SIDE)) begin
         tw = 7'(TEXTURE_MAX_SIDE);
      end else begin
         tw = cfg.texture_width;
      end
   end

   assign tc_cl    = (req_texture_column > tw - 7'd1) ? tw - 7'd1 : req_texture_column;
   assign fh_cl    = (req_wall_full_height == 16'd0) ? 16'd1 : req_wall_full_height;
   assign hl       = clamp_height_log2(cfg.height_log2);
   assign dividend = STEP_BITS'(1) << (5'(hl) + 5'(FRAC_BITS));

   // restoring divide, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[STEP_BITS-1]};
   assign ge    = trial >= {1'b0, fh_ff};

   assign start_s = START_BITS'(top_ff) + START_BITS'(fh_ff >> 1)
                  - START_BITS'(SCREEN_HEIGHT / 2);
   assign prod    = start_s * $signed({1'b0, quo_ff});

   always_comb begin
      q_push = 1'b0;
      q_data = '0;
      if (state_ff == F_PUSH) begin
         q_push        = ~q_full;
         q_data.kind   = CMD_START;
         q_data.tex    = tex_ff;
         q_data.x      = x_ff;
         q_data.top    = top_ff;
         q_data.bottom = bot_ff;
         q_data.tc     = tc_ff;
         q_data.step   = quo_ff;
         q_data.pos    = pos_ff;
      end else if (accept) begin
         unique case (req_op)
            OP_LOAD: begin
               q_push       = 1'b1;
               q_data.kind  = CMD_LOAD;
               q_data.tex   = pick_texture(req_texture_select);
               q_data.addr  = req_texel_address;
               q_data.value = req_texel_value;
            end
            OP_START: begin
               // off-screen column ends whatever column is active
               q_push      = offscreen;
               q_data.kind = CMD_END;
            end
            OP_EMIT: begin
               q_push      = 1'b1;
               q_data.kind = CMD_EMIT;
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start_col) begin
               state_in = F_DIV;
               cnt_in   = DIV_CNT_BITS'(STEP_BITS - 1);
            end
         end
         F_DIV: begin
            cnt_in = cnt_ff - DIV_CNT_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (~q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_col) begin
         x_ff   <= req_column_x;
         top_ff <= req_wall_top;
         bot_ff <= req_wall_bottom;
         tex_ff <= pick_texture(req_texture_select);
         tc_ff  <= tc_cl[TEX_SIDE_LOG2-1:0];
         fh_ff  <= fh_cl;
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (state_ff == F_DIV) begin
         rem_ff <= ge ? 16'(trial - {1'b0, fh_ff}) : trial[15:0];
         quo_ff <= {quo_ff[STEP_BITS-2:0], ge};
      end
      if (state_ff == F_MUL) begin
         pos_ff <= prod[POS_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tcr_cmd_queue.sv
// short command queue between front and back
`default_nettype none

module tcr_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tcr_pkg::cmd_type wr_data,
   output logic                  full,
   input  wire logic             pop,
   output tcr_pkg::cmd_type      rd_data,
   output logic                  empty
);
   import tcr_pkg::*;

   cmd_type                  entry_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_BITS-1:0]  count_ff;
   logic                     do_push, do_pop;

   assign full    = count_ff == CMD_CNT_BITS'(CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                       : wr_ptr_ff + CMD_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                       : rd_ptr_ff + CMD_PTR_BITS'(1);
         end
         if (do_push & ~do_pop) begin
            count_ff <= count_ff + CMD_CNT_BITS'(1);
         end else if (do_pop & ~do_push) begin
            count_ff <= count_ff - CMD_CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tcr_back.sv
// back end: column state, texture store, pixel generation and result queue
`default_nettype none

module tcr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tcr_pkg::cfg_type cfg,
   input  wire logic             q_empty,
   input  wire tcr_pkg::cmd_type q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [9:0]            rsp_pixel_x,
   output logic [8:0]            rsp_pixel_y,
   output logic [31:0]           rsp_pixel_color,
   output logic                  rsp_last_of_column
);
   import tcr_pkg::*;

   // column state
   logic [ROW_BITS-1:0]       row_ff;
   logic [10:0]               col_ff;
   logic [8:0]                top_ff, bot_ff;
   logic [1:0]                tex_ff;
   logic [TEX_SIDE_LOG2-1:0]  tc_ff;
   logic [STEP_BITS-1:0]      step_ff;
   logic [POS_BITS-1:0]       pos_ff;

   // read stage
   logic                      s1_valid_ff;
   logic [9:0]                s1_x_ff;
   logic [8:0]                s1_y_ff;
   logic                      s1_last_ff;
   logic                      s1_wall_ff;
   logic [COLOR_BITS-1:0]     s1_color_ff;

   // result queue
   logic [9:0]                ox_ff    [OUT_DEPTH];
   logic [8:0]                oy_ff    [OUT_DEPTH];
   logic [COLOR_BITS-1:0]     ocolor_ff[OUT_DEPTH];
   logic                      olast_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]   owr_ff, ord_ff;
   logic [OUT_CNT_BITS-1:0]   out_count_ff;

   logic                      space;
   logic                      active;
   logic                      emit;
   logic                      is_floor, is_ceil, is_wall;
   logic [2:0]                hl;
   logic [HEIGHT_LOG2_MAX:0]  mask_full;
   logic [HEIGHT_LOG2_MAX-1:0] ip_low, texel_row;
   logic [TEXEL_ADDR_BITS-1:0] texel_addr;
   logic [RAM_ADDR_BITS-1:0]  ram_rd_addr, ram_wr_addr;
   logic                      ram_wr_en;
   logic [COLOR_BITS-1:0]     ram_rd_data;
   logic [COLOR_BITS-1:0]     s1_out_color;
   logic                      out_pop;

   // a row request leaves the command queue only when its result has a reserved slot
   assign space  = OUT_CNT_BITS'(out_count_ff + OUT_CNT_BITS'(s1_valid_ff))
                 < OUT_CNT_BITS'(OUT_DEPTH);
   assign q_pop  = ~q_empty & ((q_data.kind != CMD_EMIT) | space);
   assign active = row_ff < ROW_BITS'(SCREEN_HEIGHT);
   assign emit   = q_pop & (q_data.kind == CMD_EMIT) & active;

   assign is_floor = row_ff > ROW_BITS'(bot_ff);
   assign is_ceil  = row_ff < ROW_BITS'(top_ff);
   assign is_wall  = ~is_floor & ~is_ceil;

   // integer part truncated toward zero, only the low bits survive the mask
   assign hl        = clamp_height_log2(cfg.height_log2);
   assign mask_full = (HEIGHT_LOG2_MAX + 1)'((HEIGHT_LOG2_MAX + 1)'(1) << hl)
                    - (HEIGHT_LOG2_MAX + 1)'(1);
   assign ip_low    = pos_ff[FRAC_BITS +: HEIGHT_LOG2_MAX]
                    + HEIGHT_LOG2_MAX'(pos_ff[POS_BITS-1] & (pos_ff[FRAC_BITS-1:0] != '0));
   assign texel_row = ip_low & mask_full[HEIGHT_LOG2_MAX-1:0];
   assign texel_addr = TEXEL_ADDR_BITS'(TEXEL_ADDR_BITS'(texel_row) << TEX_SIDE_LOG2)
                     + TEXEL_ADDR_BITS'(tc_ff);

   assign ram_rd_addr = RAM_ADDR_BITS'({tex_ff, texel_addr});
   assign ram_wr_addr = RAM_ADDR_BITS'({q_data.tex, q_data.addr});
   assign ram_wr_en   = q_pop & (q_data.kind == CMD_LOAD);

   tcr_ram #(
      .WIDTH (COLOR_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_texture_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (q_data.value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= ROW_BITS'(SCREEN_HEIGHT);
      end else if (q_pop) begin
         case (q_data.kind)
            CMD_START: row_ff <= '0;
            CMD_END:   row_ff <= ROW_BITS'(SCREEN_HEIGHT);
            CMD_EMIT: begin
               if (active) begin
                  row_ff <= row_ff + ROW_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_data.kind == CMD_START) begin
         col_ff  <= q_data.x;
         top_ff  <= q_data.top;
         bot_ff  <= q_data.bottom;
         tex_ff  <= q_data.tex;
         tc_ff   <= q_data.tc;
         step_ff <= q_data.step;
         pos_ff  <= q_data.pos;
      end else if (emit && is_wall) begin
         pos_ff <= pos_ff + POS_BITS'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_x_ff     <= col_ff[9:0];
         s1_y_ff     <= row_ff[8:0];
         s1_last_ff  <= row_ff == ROW_BITS'(SCREEN_HEIGHT - 1);
         s1_wall_ff  <= is_wall;
         s1_color_ff <= is_floor ? cfg.floor_color : cfg.ceiling_color;
      end
   end

   assign s1_out_color = s1_wall_ff ? ram_rd_data : s1_color_ff;

   assign rsp_empty          = out_count_ff == '0;
   assign out_pop            = rsp_pop & ~rsp_empty;
   assign rsp_pixel_x        = ox_ff[ord_ff];
   assign rsp_pixel_y        = oy_ff[ord_ff];
   assign rsp_pixel_color    = ocolor_ff[ord_ff];
   assign rsp_last_of_column = olast_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff       <= '0;
         ord_ff       <= '0;
         out_count_ff <= '0;
      end else begin
         if (s1_valid_ff) begin
            owr_ff <= (owr_ff == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                    : owr_ff + OUT_PTR_BITS'(1);
         end
         if (out_pop) begin
            ord_ff <= (ord_ff == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                    : ord_ff + OUT_PTR_BITS'(1);
         end
         if (s1_valid_ff & ~out_pop) begin
            out_count_ff <= out_count_ff + OUT_CNT_BITS'(1);
         end else if (out_pop & ~s1_valid_ff) begin
            out_count_ff <= out_count_ff - OUT_CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         ox_ff[owr_ff]     <= s1_x_ff;
         oy_ff[owr_ff]     <= s1_y_ff;
         ocolor_ff[owr_ff] <= s1_out_color;
         olast_ff[owr_ff]  <= s1_last_ff;
      end
   end

`ifndef SYNTHESIS
   a_slot_reserved: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (out_count_ff < OUT_CNT_BITS'(OUT_DEPTH)))
      else $error("pixel in read stage without a free result slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= OUT_CNT_BITS'(OUT_DEPTH))
      else $error("result queue count out of range");

   a_start_row: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_data.kind == CMD_START) |=> (row_ff == '0))
      else $error("column start did not clear the row counter");

   a_emit_stage: assert property (@(posedge clock) disable iff (reset)
      emit |=> s1_valid_ff)
      else $error("emitted row did not reach the read stage");
`endif

endmodule

`default_nettype wire

// File: rtl/core/textured_column_renderer.sv
// top level of the textured column renderer: registers, front, queue and back
//
// Usage: words go in on the req_ queue (push / full) and pixels come out on
// the rsp_ queue (empty / pop). op 0 loads one texel, op 1 starts a column,
// op 2 asks for the next row's pixel. The csr_ port writes ceiling color,
// floor color, texture width and texture height log2; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// A texel load or a row request is taken every cycle while full stays low.
// A column start holds full high while the front divides out the 7.16 step,
// one quotient bit per cycle, then multiplies the start position; row
// requests queued earlier keep draining meanwhile. A pixel passes through
// the command queue, the texture memory read and the result queue on its way
// to the rsp_ ports, and rows stream at one per cycle while pop stays high.
// When the receiver stops popping, the four-word result queue fills, the
// back stops taking commands, the command queue fills and full rises.
// Reset is synchronous: it empties both queues, ends any active column and
// restores the register defaults; texture memory contents are kept as is
// and must be loaded before use.
`default_nettype none

module textured_column_renderer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_op,
   input  wire logic [1:0]  req_texture_select,
   input  wire logic [11:0] req_texel_address,
   input  wire logic [31:0] req_texel_value,
   input  wire logic [10:0] req_column_x,
   input  wire logic [8:0]  req_wall_top,
   input  wire logic [8:0]  req_wall_bottom,
   input  wire logic [15:0] req_wall_full_height,
   input  wire logic [6:0]  req_texture_column,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [9:0]       rsp_pixel_x,
   output logic [8:0]       rsp_pixel_y,
   output logic [31:0]      rsp_pixel_color,
   output logic             rsp_last_of_column,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   import tcr_pkg::*;

   logic [COLOR_BITS-1:0] ceiling_ff, floor_ff;
   logic [6:0]            tex_width_ff;
   logic [2:0]            height_log2_ff;
   cfg_type               cfg;

   logic                  q_push, q_full, q_pop, q_empty;
   cmd_type               q_wr_data, q_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff     <= '0;
         floor_ff       <= '0;
         tex_width_ff   <= 7'(TEXTURE_MAX_SIDE);
         height_log2_ff <= 3'(HEIGHT_LOG2_MAX);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CEILING:     ceiling_ff     <= csr_write_data;
            CSR_FLOOR:       floor_ff       <= csr_write_data;
            CSR_TEX_WIDTH:   tex_width_ff   <= csr_write_data[6:0];
            CSR_HEIGHT_LOG2: height_log2_ff <= csr_write_data[2:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.ceiling_color = ceiling_ff;
   assign cfg.floor_color   = floor_ff;
   assign cfg.texture_width = tex_width_ff;
   assign cfg.height_log2   = height_log2_ff;

   tcr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_op               (req_op),
      .req_texture_select   (req_texture_select),
      .req_texel_address    (req_texel_address),
      .req_texel_value      (req_texel_value),
      .req_column_x         (req_column_x),
      .req_wall_top         (req_wall_top),
      .req_wall_bottom      (req_wall_bottom),
      .req_wall_full_height (req_wall_full_height),
      .req_texture_column   (req_texture_column),
      .cfg                  (cfg),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_data               (q_wr_data)
   );

   tcr_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   tcr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .q_empty            (q_empty),
      .q_data             (q_rd_data),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_last_of_column (rsp_last_of_column)
   );

endmodule

`default_nettype wire
